// ===== design/hdec_pkg.sv =====
// package: shared types, codes and constants of the squeezed-data decoder
`timescale 1ns / 1ps
`default_nettype none
package hdec_pkg;

	localparam int MAX_NODES   = 256;
	localparam int NODE_AW     = $clog2(MAX_NODES);
	localparam int SIZE_W      = $clog2(MAX_NODES + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0]  RLE_ESCAPE   = 8'h90;
	localparam logic [24:0] LENGTH_LIMIT = 25'd16777216;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_DATA  = 2'd2;
	localparam logic [1:0] REQ_END   = 2'd3;

	localparam logic [2:0] ST_RUNNING   = 3'd0;
	localparam logic [2:0] ST_DONE      = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_BADLINK   = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         node_index;
		logic signed [15:0] zero_link;
		logic signed [15:0] one_link;
		logic [8:0]         node_count;
		logic [24:0]        out_length;
		logic [7:0]         data_byte;
	} hdec_req_t;

	typedef struct packed {
		logic [7:0] run_value;
		logic [7:0] run_length;
		logic       last;
		logic [2:0] status;
	} hdec_rsp_t;

	typedef enum logic [1:0] {K_LOAD, K_START, K_DATA, K_END} hdec_kind_t;

	// classified command handed from front to back
	typedef struct packed {
		hdec_kind_t          kind;
		logic [NODE_AW-1:0]  node;
		logic [31:0]         links;
		logic [SIZE_W-1:0]   size;
		logic [24:0]         length;
		logic                len_bad;
		logic [7:0]          data_byte;
	} hdec_cmd_t;

endpackage
`default_nettype wire

// ===== design/hdec_front.sv =====
// front end: accepts items, classifies them and queues commands for the back end
`timescale 1ns / 1ps
`default_nettype none
module hdec_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  hdec_pkg::hdec_req_t req,
	output logic                cmd_valid,
	input  wire                 cmd_pop,
	output hdec_pkg::hdec_cmd_t cmd
);
	import hdec_pkg::*;

	hdec_cmd_t           fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	hdec_cmd_t           cls;
	logic                keep;
	logic                push;

	always_comb begin
		cls           = '0;
		cls.node      = NODE_AW'(req.node_index);
		cls.links     = {req.one_link, req.zero_link};
		cls.size      = (32'(req.node_count) > 32'(MAX_NODES)) ? SIZE_W'(MAX_NODES)
		                                                       : SIZE_W'(req.node_count);
		cls.length    = req.out_length;
		cls.len_bad   = req.out_length > LENGTH_LIMIT;
		cls.data_byte = req.data_byte;
		keep          = 1'b1;
		case (req.req_type)
			REQ_LOAD: begin
				cls.kind = K_LOAD;
				// loads beyond the store are dropped here
				keep     = 32'(req.node_index) < 32'(MAX_NODES);
			end
			REQ_START: cls.kind = K_START;
			REQ_DATA:  cls.kind = K_DATA;
			REQ_END:   cls.kind = K_END;
			default:   cls.kind = K_END;
		endcase
	end

	assign req_stall = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign push      = req_valid && !req_stall && keep;
	assign cmd_valid = count_q != '0;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/hdec_back.sv =====
// back end: tree store, bit-serial tree walk, rle expansion and result register
`timescale 1ns / 1ps
`default_nettype none
module hdec_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_pop,
	input  hdec_pkg::hdec_cmd_t cmd,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output hdec_pkg::hdec_rsp_t rsp
);
	import hdec_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_t;

	logic [31:0]        mem [MAX_NODES];
	logic [31:0]        rd_q;
	logic               wr_en;

	state_t             st_q, st_d;
	logic [SIZE_W-1:0]  size_q, size_d;
	logic [NODE_AW-1:0] pos_q, pos_d;
	logic               esc_q, esc_d;
	logic [7:0]         prev_q, prev_d;
	logic [24:0]        rem_q, rem_d;
	logic [2:0]         err_q, err_d;
	logic [7:0]         byte_q, byte_d;
	logic [2:0]         bit_q, bit_d;
	logic               pend_valid_q, pend_valid_d;
	hdec_rsp_t          pend_q, pend_d;
	logic               out_valid_q, out_valid_d;
	hdec_rsp_t          out_q, out_d;

	logic               out_free;
	logic               emit;
	hdec_rsp_t          emit_data;
	logic [15:0]        link;
	logic [7:0]         sym;
	logic [7:0]         count;
	logic               ev;
	hdec_rsp_t          res;
	logic [2:0]         n_err;
	logic [NODE_AW-1:0] n_pos;
	logic               n_esc;
	logic [7:0]         n_prev;
	logic [24:0]        n_rem;
	logic               hold;

	assign out_free = !out_valid_q || !rsp_stall;
	assign link     = byte_q[0] ? rd_q[31:16] : rd_q[15:0];
	assign sym      = ~link[7:0];
	assign count    = sym - 8'd1;

	// one walk step, evaluated before the stall decision
	always_comb begin
		n_err  = err_q;
		n_pos  = pos_q;
		n_esc  = esc_q;
		n_prev = prev_q;
		n_rem  = rem_q;
		ev     = 1'b0;
		res    = '0;
		if (32'(pos_q) >= 32'(size_q)) begin
			n_err      = ST_BADLINK;
			ev         = 1'b1;
			res.status = ST_BADLINK;
		end else if (!link[15]) begin
			if (32'(link[14:0]) >= 32'(size_q)) begin
				n_err      = ST_BADLINK;
				ev         = 1'b1;
				res.status = ST_BADLINK;
			end else begin
				n_pos = NODE_AW'(link[14:0]);
			end
		end else begin
			n_pos = '0;
			if (esc_q) begin
				n_esc = 1'b0;
				if (sym == 8'd0) begin
					// escape followed by zero: literal escape byte
					n_prev = RLE_ESCAPE;
					n_rem  = rem_q - 25'd1;
					if (n_rem == '0) begin
						n_err = ST_DONE;
					end
					ev  = 1'b1;
					res = '{run_value: RLE_ESCAPE, run_length: 8'd1, last: 1'b0,
					        status: n_err};
				end else if (25'(count) > rem_q) begin
					n_err      = ST_OVERFLOW;
					ev         = 1'b1;
					res.status = ST_OVERFLOW;
				end else if (count != 8'd0) begin
					n_rem = rem_q - 25'(count);
					if (n_rem == '0) begin
						n_err = ST_DONE;
					end
					ev  = 1'b1;
					res = '{run_value: prev_q, run_length: count, last: 1'b0,
					        status: n_err};
				end
			end else if (sym == RLE_ESCAPE) begin
				n_esc = 1'b1;
			end else begin
				n_prev = sym;
				n_rem  = rem_q - 25'd1;
				if (n_rem == '0) begin
					n_err = ST_DONE;
				end
				ev  = 1'b1;
				res = '{run_value: sym, run_length: 8'd1, last: 1'b0, status: n_err};
			end
		end
	end

	always_comb begin
		st_d         = st_q;
		size_d       = size_q;
		pos_d        = pos_q;
		esc_d        = esc_q;
		prev_d       = prev_q;
		rem_d        = rem_q;
		err_d        = err_q;
		byte_d       = byte_q;
		bit_d        = bit_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		cmd_pop      = 1'b0;
		wr_en        = 1'b0;
		emit         = 1'b0;
		emit_data    = '0;
		hold         = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						K_LOAD: begin
							cmd_pop = 1'b1;
							wr_en   = 1'b1;
						end
						K_DATA: begin
							cmd_pop = 1'b1;
							if (err_q == ST_RUNNING && rem_q != '0) begin
								st_d   = S_WALK;
								byte_d = cmd.data_byte;
								bit_d  = '0;
							end
						end
						K_START: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								size_d  = cmd.size;
								pos_d   = '0;
								esc_d   = 1'b0;
								prev_d  = '0;
								if (cmd.len_bad) begin
									rem_d = '0;
									err_d = ST_OVERFLOW;
								end else begin
									rem_d = cmd.length;
									err_d = (cmd.length == '0) ? ST_DONE : ST_RUNNING;
								end
								emit             = 1'b1;
								emit_data.last   = 1'b1;
								emit_data.status = err_d;
							end
						end
						K_END: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								if (err_q == ST_RUNNING) begin
									err_d = (rem_q != '0) ? ST_EXHAUSTED : ST_DONE;
								end
								emit             = 1'b1;
								emit_data.last   = 1'b1;
								emit_data.status = err_d;
							end
						end
						default: ;
					endcase
				end
			end
			S_WALK: begin
				// a new result pushes the held one out, so wait for room
				hold = ev && pend_valid_q && !out_free;
				if (!hold) begin
					err_d  = n_err;
					pos_d  = n_pos;
					esc_d  = n_esc;
					prev_d = n_prev;
					rem_d  = n_rem;
					if (ev) begin
						if (pend_valid_q) begin
							emit      = 1'b1;
							emit_data = pend_q;
						end
						pend_valid_d = 1'b1;
						pend_d       = res;
					end
					bit_d  = bit_q + 3'd1;
					byte_d = byte_q >> 1;
					if (n_err != ST_RUNNING || bit_q == 3'd7) begin
						st_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q) begin
					st_d = S_IDLE;
				end else if (out_free) begin
					emit           = 1'b1;
					emit_data      = pend_q;
					emit_data.last = 1'b1;
					pend_valid_d   = 1'b0;
					st_d           = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase

		out_valid_d = out_valid_q;
		out_d       = out_q;
		if (emit) begin
			out_valid_d = 1'b1;
			out_d       = emit_data;
		end else if (!rsp_stall) begin
			out_valid_d = 1'b0;
		end
	end

	// tree store, one row per node holding both links
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd.node] <= cmd.links;
		end
		rd_q <= mem[pos_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			size_q       <= SIZE_W'(1);
			pos_q        <= '0;
			esc_q        <= 1'b0;
			prev_q       <= '0;
			rem_q        <= '0;
			err_q        <= ST_RUNNING;
			bit_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q         <= st_d;
			size_q       <= size_d;
			pos_q        <= pos_d;
			esc_q        <= esc_d;
			prev_q       <= prev_d;
			rem_q        <= rem_d;
			err_q        <= err_d;
			bit_q        <= bit_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		pend_q <= pend_d;
		out_q  <= out_d;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_no_pend_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> !pend_valid_q)
		else $error("held result left over between items");

	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.run_length == 8'd0 |-> out_q.last)
		else $error("status-only result not marked last");

	a_walk_running: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WALK |-> err_q == ST_RUNNING && rem_q != '0)
		else $error("tree walk continued after completion or error");

	a_flush_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_FLUSH && !pend_valid_q |=> st_q == S_IDLE)
		else $error("flush did not return to idle");

endmodule
`default_nettype wire

// ===== design/huffman_tree_rle_decoder.sv =====
// top level of the squeezed-data decoder: front end, command queue and back end
//
//  channel | direction | payload     | handshake
//  req     | in        | hdec_req_t  | req_valid / req_stall
//  rsp     | out       | hdec_rsp_t  | rsp_valid / rsp_stall
//
// a walked data byte passes the back end in order: one tree-store read, then one
// node per cycle for its eight bits while the result register has room, then the
// release of its final run; a walk that completes or fails stops early, a dropped
// byte is only popped; start and end wait for room; the front queue holds four
// reset clears the walk state and sets the tree size to one; the tree store
// is not cleared and must be loaded before use
// a stalled result register holds the walk on the next run it would produce
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_rle_decoder (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  hdec_pkg::hdec_req_t req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output hdec_pkg::hdec_rsp_t rsp
);
	import hdec_pkg::*;

	logic      cmd_valid;
	logic      cmd_pop;
	hdec_cmd_t cmd;

	hdec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	hdec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
